FILE: hw/rtl/note_tone_sequencer_assert.svh
// assertion macros for the note tone sequencer
// no dependencies; included by note_tone_sequencer.sv
`ifndef NOTE_TONE_SEQUENCER_ASSERT_SVH
`define NOTE_TONE_SEQUENCER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define NTS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define NTS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/nts_pkg.sv
// shared types and constants of the note tone sequencer
// no dependencies; imported by note_tone_sequencer
package nts_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_RUN,
    ST_FINISH
  } nts_state_t;

  // request op codes
  localparam logic [2:0] OP_LOAD      = 3'd0;
  localparam logic [2:0] OP_REWIND    = 3'd1;
  localparam logic [2:0] OP_RESUME    = 3'd2;
  localparam logic [2:0] OP_PAUSE     = 3'd3;
  localparam logic [2:0] OP_NOTE_DONE = 3'd4;

  // configuration register indexes
  localparam logic [1:0] REG_ENTRY_COUNT  = 2'd0;
  localparam logic [1:0] REG_VOLUME       = 2'd1;
  localparam logic [1:0] REG_BEAT_TICKS   = 2'd2;
  localparam logic [1:0] REG_PLAY_FORWARD = 2'd3;

  localparam int PERIOD_W   = 22;
  localparam int DUTY_W     = 21;
  localparam int DUR_W      = 32;
  localparam int NOTE_W     = 8;
  localparam int SHOWN_W    = 9;
  localparam int VOL_W      = 7;
  localparam int SLEN_W     = 9;
  localparam int PROD_W     = PERIOD_W + VOL_W;
  localparam int ROM_DEPTH  = 256;

  localparam logic [PERIOD_W-1:0] PERIOD_MAX = '1;
  localparam logic [DUTY_W-1:0]   DUTY_MAX   = '1;

  localparam int          A4_NOTE       = 69;
  localparam int          SEMITONES     = 12;
  localparam logic [7:0]  DUTY_DIVISOR  = 8'd200;
  localparam logic [63:0] NOTE_DEN      = 64'd440 * 64'd1000000000;

  // 2^(r/12) scaled by 1e9, rounded to nearest
  localparam logic [63:0] SEMITONE_RATIO [SEMITONES] = '{
    64'd1000000000, 64'd1059463094, 64'd1122462048, 64'd1189207115,
    64'd1259921050, 64'd1334839854, 64'd1414213562, 64'd1498307077,
    64'd1587401052, 64'd1681792831, 64'd1781797436, 64'd1887748625
  };

  // serial step counts
  localparam int MUL_STEPS  = VOL_W;
  localparam int DUTY_STEPS = PROD_W;
  localparam int DUR_STEPS  = DUR_W;
  localparam int RUN_STEPS  = MUL_STEPS + DUTY_STEPS;

endpackage

FILE: hw/rtl/note_tone_sequencer.sv
// note tone sequencer top level: song memory, period rom, serial maths
// depends on nts_pkg and note_tone_sequencer_assert.svh
//  - s_* channel takes requests: load an entry, rewind, resume, pause or
//    note finished. loads, rewinds and pauses are handled in the idle state
//  - m_* channel gives one tone command per resume or note finished while
//    playing; running off either end gives one end result (m_tuser set,
//    all data zero) and stops play
//  - cfg_* writes the four registers; write only while the block is idle
//  - a tone request reads the registered song memory, then the read state
//    does the rom lookup, the run state does the serial maths (7 shift-add
//    steps for period times volume, then 29 restoring steps dividing by
//    200, the 32-step beat division alongside) and the finish state loads
//    the output register; an end result skips the read and run states
//  - one tone at a time: the next request is taken once the result has
//    moved to the output register
//  - a stalled receiver holds the next result in the finish state and
//    blocks new requests until the output register frees
//  - reset (synchronous, rst high) stops play, sets the position to the
//    first entry and plays forward; song memory content stays undefined
//    until loaded
module note_tone_sequencer
  import nts_pkg::*;
#(
  parameter int SONG_DEPTH = 256,
  parameter int NOTE_TOTAL = 132,
  parameter int CLOCK_HZ   = 16000000
) (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        s_tvalid,
  output logic        s_tready,
  // op[2:0], entry_address[10:3], note_number[18:11], note_divisor[26:19]
  input  logic [31:0] s_tdata,
  // result channel
  output logic        m_tvalid,
  input  logic        m_tready,
  // tone_period[21:0], tone_duty[42:22], tone_duration[74:43],
  // played_note[82:75], position_shown[91:83]
  output logic [95:0] m_tdata,
  // song_over[0]
  output logic        m_tuser,
  // configuration writes
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [31:0] cfg_wdata
);

  localparam int AW = $clog2(SONG_DEPTH);
  localparam int LW = $clog2(SONG_DEPTH + 1);
  localparam int PW = LW + 1;

  `include "note_tone_sequencer_assert.svh"

  // request fields
  logic [2:0]        in_op;
  logic [7:0]        in_addr;
  logic [NOTE_W-1:0] in_note;
  logic [7:0]        in_div;

  assign in_op   = s_tdata[2:0];
  assign in_addr = s_tdata[10:3];
  assign in_note = s_tdata[18:11];
  assign in_div  = s_tdata[26:19];

  // configuration registers
  logic [SLEN_W-1:0] entry_count;
  logic [VOL_W-1:0]  volume_percent;
  logic [DUR_W-1:0]  beat_ticks;
  logic              play_forward;

  // control state
  nts_state_t        state, state_next;
  logic              playing;
  logic signed [PW-1:0] pos;
  logic [5:0]        cnt;
  logic              end_flag;

  // period rom, one entry per note code, zero beyond the note range
  logic [PERIOD_W-1:0] period_rom [ROM_DEPTH];

  for (genvar g = 0; g < ROM_DEPTH; g++) begin : g_rom
    localparam int D = A4_NOTE - g;
    localparam int R = ((D % SEMITONES) + SEMITONES) % SEMITONES;
    localparam int Q = (D - R) / SEMITONES;
    localparam logic [63:0] NUM =
      (64'(CLOCK_HZ) * SEMITONE_RATIO[R]) << ((Q > 0) ? Q : 0);
    localparam logic [63:0] DEN = NOTE_DEN << ((Q < 0) ? -Q : 0);
    localparam logic [63:0] PER = NUM / DEN;
    localparam logic [PERIOD_W-1:0] ENTRY =
      (g >= NOTE_TOTAL) ? '0 :
      ((PER > 64'(PERIOD_MAX)) ? PERIOD_MAX : PER[PERIOD_W-1:0]);
    assign period_rom[g] = ENTRY;
  end

  // song memory: note in the high byte, divisor in the low byte
  logic [15:0] song_mem [SONG_DEPTH];
  logic [15:0] rd_data;

  // serial datapath
  logic [PERIOD_W-1:0] period_reg;
  logic [NOTE_W-1:0]   note_reg;
  logic [7:0]          div_reg;
  logic [VOL_W-1:0]    vol_sh;
  logic [PROD_W-1:0]   prod;
  logic [7:0]          duty_rem;
  logic [DUR_W-1:0]    beat_sh;
  logic [7:0]          dur_rem;
  logic [SHOWN_W-1:0]  shown;

  // output register
  logic [PERIOD_W-1:0] out_period;
  logic [DUTY_W-1:0]   out_duty;
  logic [DUR_W-1:0]    out_duration;
  logic [NOTE_W-1:0]   out_note;
  logic [SHOWN_W-1:0]  out_shown;
  logic                out_over;

  // derived control
  logic          accept;
  logic          advance;
  logic          in_range;
  logic          out_load;
  logic          run_last;
  logic          load_ok;
  logic [LW-1:0] eff_len;
  logic [LW:0]   pos_inc;

  // song length clamped to the memory depth
  assign eff_len  = (32'(entry_count) > SONG_DEPTH) ? LW'(SONG_DEPTH) : LW'(entry_count);
  assign in_range = !pos[PW-1] && (pos[LW-1:0] < eff_len);
  assign pos_inc  = (LW + 1)'(pos[LW-1:0]) + (LW + 1)'(1);
  assign load_ok  = 32'(in_addr) < SONG_DEPTH;

  // outputs of the controller
  always_comb begin
    s_tready = (state == ST_IDLE);
    accept   = s_tvalid && s_tready;
    advance  = accept && ((in_op == OP_RESUME) || ((in_op == OP_NOTE_DONE) && playing));
    out_load = (state == ST_FINISH) && (!m_tvalid || m_tready);
    run_last = (state == ST_RUN) && (cnt == 6'(RUN_STEPS - 1));
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (advance) begin
          state_next = in_range ? ST_READ : ST_FINISH;
        end
      end
      ST_READ:   state_next = ST_RUN;
      ST_RUN: begin
        if (run_last) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      playing        <= 1'b0;
      pos            <= '0;
      cnt            <= '0;
      end_flag       <= 1'b0;
      m_tvalid       <= 1'b0;
      entry_count    <= '0;
      volume_percent <= '0;
      beat_ticks     <= '0;
      play_forward   <= 1'b1;
    end else begin
      state <= state_next;

      if (cfg_we) begin
        unique case (cfg_addr)
          REG_ENTRY_COUNT:  entry_count    <= cfg_wdata[SLEN_W-1:0];
          REG_VOLUME:       volume_percent <= cfg_wdata[VOL_W-1:0];
          REG_BEAT_TICKS:   beat_ticks     <= cfg_wdata[DUR_W-1:0];
          REG_PLAY_FORWARD: play_forward   <= cfg_wdata[0];
          default:          ;
        endcase
      end

      if (accept) begin
        unique case (in_op)
          OP_REWIND: begin
            playing <= 1'b0;
            pos     <= play_forward ? '0 : $signed(PW'(eff_len)) - PW'(1);
          end
          OP_PAUSE:  playing <= 1'b0;
          default:   ;
        endcase
      end

      // a step keeps play on inside the song; stepping off the end clears it
      if (advance) begin
        end_flag <= !in_range;
        playing  <= in_range;
        if (in_range) begin
          if (play_forward) begin
            pos <= pos + PW'(1);
          end else begin
            pos <= pos - PW'(1);
          end
        end
      end

      if (state == ST_RUN) begin
        cnt <= cnt + 6'd1;
      end else begin
        cnt <= '0;
      end

      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // song memory write and registered read
  always_ff @(posedge clk) begin
    if (accept && (in_op == OP_LOAD) && load_ok) begin
      song_mem[AW'(in_addr)] <= {in_note, in_div};
    end
    if (advance) begin
      rd_data <= song_mem[pos[AW-1:0]];
      shown   <= SHOWN_W'(pos_inc);
    end
  end

  // serial maths: shift-add multiply then divide by 200, beat division alongside
  logic [8:0] dur_trial;
  logic [8:0] duty_trial;
  logic       dur_fit;
  logic       duty_fit;

  assign dur_trial  = {dur_rem, beat_sh[DUR_W-1]};
  assign dur_fit    = dur_trial >= {1'b0, div_reg};
  assign duty_trial = {duty_rem, prod[PROD_W-1]};
  assign duty_fit   = duty_trial >= {1'b0, DUTY_DIVISOR};

  always_ff @(posedge clk) begin
    if (state == ST_READ) begin
      note_reg   <= rd_data[15:8];
      div_reg    <= rd_data[7:0];
      period_reg <= period_rom[rd_data[15:8]];
      vol_sh     <= volume_percent;
      beat_sh    <= beat_ticks;
      prod       <= '0;
      duty_rem   <= '0;
      dur_rem    <= '0;
    end else if (state == ST_RUN) begin
      if (cnt < 6'(DUR_STEPS)) begin
        dur_rem <= dur_fit ? 8'(dur_trial - {1'b0, div_reg}) : dur_trial[7:0];
        beat_sh <= {beat_sh[DUR_W-2:0], dur_fit};
      end
      if (cnt < 6'(MUL_STEPS)) begin
        prod   <= {prod[PROD_W-2:0], 1'b0} + (vol_sh[VOL_W-1] ? PROD_W'(period_reg) : '0);
        vol_sh <= {vol_sh[VOL_W-2:0], 1'b0};
      end else begin
        duty_rem <= duty_fit ? 8'(duty_trial - {1'b0, DUTY_DIVISOR}) : duty_trial[7:0];
        prod     <= {prod[PROD_W-2:0], duty_fit};
      end
    end
  end

  // output register load
  always_ff @(posedge clk) begin
    if (out_load) begin
      if (end_flag) begin
        out_period   <= '0;
        out_duty     <= '0;
        out_duration <= '0;
        out_note     <= '0;
        out_shown    <= '0;
        out_over     <= 1'b1;
      end else begin
        out_period   <= period_reg;
        out_duty     <= (prod > PROD_W'(DUTY_MAX)) ? DUTY_MAX : prod[DUTY_W-1:0];
        out_duration <= (div_reg == 8'd0) ? '1 : beat_sh;
        out_note     <= note_reg;
        out_shown    <= shown;
        out_over     <= 1'b0;
      end
    end
  end

  assign m_tdata = {4'd0, out_shown, out_note, out_duration, out_duty, out_period};
  assign m_tuser = out_over;

  // checks
  `NTS_ASSERT_NEXT(a_run_ends, clk, rst, run_last, state == ST_FINISH, "serial run overran")
  `NTS_ASSERT_NOW(a_end_silent, clk, rst, m_tvalid && m_tuser, m_tdata == '0, "end result has tone data")
  `NTS_ASSERT_NOW(a_end_stops, clk, rst, (state == ST_FINISH) && end_flag, !playing, "play continues past song end")
  `NTS_ASSERT_NOW(a_pos_range, clk, rst, pos[PW-1], pos == {PW{1'b1}}, "position below first entry minus one")

endmodule
